// ===== rtl/wf3_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_pkg
// Shared types and constants for the 3x3 window filter.
// ----------------------------------------------------------------------------
package wf3_pkg;

   localparam int PIX_W       = 8;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);

   localparam int MODE_W      = 2;
   localparam int WIDTH_W     = 11;
   localparam int HEIGHT_W    = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_HEIGHT = 2'd2;

   localparam logic [MODE_W-1:0] MODE_BOX   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_GAUSS = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LAP   = 2'd2;

   localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = 11'd640;
   localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = 13'd480;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = Q_PTR_W + 1;

   // reciprocal multipliers, exact for the value ranges in use
   localparam int SUM_W       = 12;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 15;
   localparam logic [RECIP_W-1:0] BOX_RECIP   = 13'd3641;
   localparam logic [RECIP_W-1:0] GAUSS_RECIP = 13'd5462;

   typedef logic [8:0][PIX_W-1:0] window_type;

   typedef struct packed {
      window_type win;
      logic       frame_end;
   } q_item_type;

endpackage

// ===== rtl/window_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_filter_3x3
// Streaming 3x3 filter (box mean, cross Gaussian, clamped Laplacian) on
// 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Takes one pixel per clock and emits one result per interior pixel, the
// filtered value centred one row and one column back; border pixels give no
// beat. A pixel flows through the line store read, a four-entry queue, then
// the operand and result registers of the arithmetic. The input stalls only
// when the queue backs up behind a stalled output, and after reset while the
// line store is zeroed. Configuration writes are taken at any time but
// should be made between beats.
// ----------------------------------------------------------------------------
module window_filter_3x3 (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [wf3_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic                              req_frame_start,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [wf3_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic                              rsp_frame_end,
   input  logic                              csr_we,
   input  logic [wf3_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [wf3_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [wf3_pkg::MODE_W-1:0]    mode_ff;
   logic [wf3_pkg::WIDTH_W-1:0]   width_ff;
   logic [wf3_pkg::HEIGHT_W-1:0]  height_ff;

   logic                          q_push, q_pop, q_head_valid;
   wf3_pkg::q_item_type           q_push_item, q_head_item;
   logic [wf3_pkg::Q_CNT_W-1:0]   q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= wf3_pkg::MODE_BOX;
         width_ff  <= wf3_pkg::RESET_WIDTH;
         height_ff <= wf3_pkg::RESET_HEIGHT;
      end else if (csr_we) begin
         case (csr_index)
            wf3_pkg::CSR_FILTER_MODE: begin
               mode_ff <= csr_wdata[wf3_pkg::MODE_W-1:0];
            end
            wf3_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[wf3_pkg::WIDTH_W-1:0];
            end
            wf3_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[wf3_pkg::HEIGHT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   wf3_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .image_width     (width_ff),
      .image_height    (height_ff),
      .q_count         (q_count),
      .q_push          (q_push),
      .q_push_item     (q_push_item)
   );

   wf3_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_push_item),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_item  (q_head_item),
      .count      (q_count)
   );

   wf3_back u_back (
      .clock         (clock),
      .reset         (reset),
      .filter_mode   (mode_ff),
      .head_valid    (q_head_valid),
      .head_item     (q_head_item),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

// ===== rtl/wf3_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_front
// Position counters, two-row line store and 3x3 window; forwards interior
// windows to the queue.
// ----------------------------------------------------------------------------
module wf3_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [wf3_pkg::PIX_W-1:0]       req_pixel_in,
   input  logic                            req_frame_start,
   input  logic [wf3_pkg::WIDTH_W-1:0]     image_width,
   input  logic [wf3_pkg::HEIGHT_W-1:0]    image_height,
   input  logic [wf3_pkg::Q_CNT_W-1:0]     q_count,
   output logic                            q_push,
   output wf3_pkg::q_item_type             q_push_item
);

   // one word per column: upper byte is two rows back, lower byte one row back
   logic [2*wf3_pkg::PIX_W-1:0] line_mem [wf3_pkg::MAX_WIDTH];
   logic [2*wf3_pkg::PIX_W-1:0] mem_rd_ff;

   logic                          clear_busy_ff;
   logic [wf3_pkg::COL_W-1:0]     clear_cnt_ff;

   logic [wf3_pkg::COL_W-1:0]     col_ff, col_in;
   logic [wf3_pkg::ROW_W-1:0]     row_ff, row_in;

   logic                          s1_valid_ff;
   logic [wf3_pkg::COL_W-1:0]     s1_addr_ff;
   logic [wf3_pkg::PIX_W-1:0]     s1_pix_ff;
   logic                          s1_interior_ff;
   logic                          s1_fend_ff;
   logic                          s1_byp_ff;
   logic [2*wf3_pkg::PIX_W-1:0]   s1_byp_data_ff;

   wf3_pkg::window_type           win_ff, win_in;

   logic [wf3_pkg::WIDTH_W-1:0]   w_eff;
   logic [wf3_pkg::HEIGHT_W-1:0]  h_eff;
   logic [wf3_pkg::COL_W-1:0]     c;
   logic [wf3_pkg::ROW_W-1:0]     r;
   logic                          last_col, last_row, interior, accept;
   logic [2*wf3_pkg::PIX_W-1:0]   rd_word, wr_word;
   logic [wf3_pkg::PIX_W-1:0]     top, mid;

   always_comb begin
      if (image_width < wf3_pkg::WIDTH_W'(3)) begin
         w_eff = wf3_pkg::WIDTH_W'(3);
      end else if (image_width > wf3_pkg::WIDTH_W'(wf3_pkg::MAX_WIDTH)) begin
         w_eff = wf3_pkg::WIDTH_W'(wf3_pkg::MAX_WIDTH);
      end else begin
         w_eff = image_width;
      end
      if (image_height < wf3_pkg::HEIGHT_W'(3)) begin
         h_eff = wf3_pkg::HEIGHT_W'(3);
      end else if (image_height > wf3_pkg::HEIGHT_W'(wf3_pkg::MAX_HEIGHT)) begin
         h_eff = wf3_pkg::HEIGHT_W'(wf3_pkg::MAX_HEIGHT);
      end else begin
         h_eff = image_height;
      end
   end

   assign req_stall = clear_busy_ff ||
                      (({1'b0, q_count} + {{wf3_pkg::Q_CNT_W{1'b0}}, s1_valid_ff})
                       >= (wf3_pkg::Q_CNT_W + 1)'(wf3_pkg::Q_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign c = req_frame_start ? '0 : col_ff;
   assign r = req_frame_start ? '0 : row_ff;

   assign last_col = (wf3_pkg::WIDTH_W'(c) + wf3_pkg::WIDTH_W'(1)) >= w_eff;
   assign last_row = (wf3_pkg::HEIGHT_W'(r) + wf3_pkg::HEIGHT_W'(1)) >= h_eff;
   assign interior = (r >= wf3_pkg::ROW_W'(2)) && (c >= wf3_pkg::COL_W'(2));

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : r + wf3_pkg::ROW_W'(1);
         end else begin
            col_in = c + wf3_pkg::COL_W'(1);
            row_in = r;
         end
      end
   end

   // second half of a beat: read data back, shift window, write rows down
   assign rd_word = s1_byp_ff ? s1_byp_data_ff : mem_rd_ff;
   assign top     = rd_word[2*wf3_pkg::PIX_W-1:wf3_pkg::PIX_W];
   assign mid     = rd_word[wf3_pkg::PIX_W-1:0];
   assign wr_word = {mid, s1_pix_ff};

   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_in[k*3]   = win_ff[k*3+1];
            win_in[k*3+1] = win_ff[k*3+2];
         end
         win_in[2] = top;
         win_in[5] = mid;
         win_in[8] = s1_pix_ff;
      end
   end

   assign q_push                = s1_valid_ff && s1_interior_ff;
   assign q_push_item.win       = win_in;
   assign q_push_item.frame_end = s1_fend_ff;

   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         line_mem[clear_cnt_ff] <= '0;
      end else if (s1_valid_ff) begin
         line_mem[s1_addr_ff] <= wr_word;
      end
      if (accept) begin
         mem_rd_ff <= line_mem[c];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_addr_ff     <= c;
         s1_pix_ff      <= req_pixel_in;
         s1_interior_ff <= interior;
         s1_fend_ff     <= last_col && last_row;
         s1_byp_ff      <= s1_valid_ff && (s1_addr_ff == c);
         s1_byp_data_ff <= wr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_cnt_ff  <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
         s1_valid_ff   <= 1'b0;
         win_ff        <= '0;
      end else begin
         if (clear_busy_ff) begin
            clear_cnt_ff <= clear_cnt_ff + wf3_pkg::COL_W'(1);
            if (clear_cnt_ff == wf3_pkg::COL_W'(wf3_pkg::MAX_WIDTH - 1)) begin
               clear_busy_ff <= 1'b0;
            end
         end
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= accept;
         win_ff      <= win_in;
      end
   end

endmodule

// ===== rtl/wf3_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_queue
// Small first-in first-out buffer of windows between front and back.
// ----------------------------------------------------------------------------
module wf3_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  wf3_pkg::q_item_type           push_item,
   input  logic                          pop,
   output logic                          head_valid,
   output wf3_pkg::q_item_type           head_item,
   output logic [wf3_pkg::Q_CNT_W-1:0]   count
);

   wf3_pkg::q_item_type               slot_ff [wf3_pkg::Q_DEPTH];
   logic [wf3_pkg::Q_PTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [wf3_pkg::Q_CNT_W-1:0]       count_ff;
   logic                              do_pop;

   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];
   assign count      = count_ff;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + wf3_pkg::Q_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + wf3_pkg::Q_PTR_W'(1);
         end
         if (push && !do_pop) begin
            count_ff <= count_ff + wf3_pkg::Q_CNT_W'(1);
         end else if (do_pop && !push) begin
            count_ff <= count_ff - wf3_pkg::Q_CNT_W'(1);
         end
      end
   end

endmodule

// ===== rtl/wf3_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wf3_back
// Filter arithmetic: window sums, then reciprocal multiply or clamp into the
// result register.
// ----------------------------------------------------------------------------
module wf3_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [wf3_pkg::MODE_W-1:0]    filter_mode,
   input  logic                          head_valid,
   input  wf3_pkg::q_item_type           head_item,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [wf3_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic                          rsp_frame_end
);

   logic                          a_valid_ff;
   logic [wf3_pkg::SUM_W-1:0]     a_operand_ff;
   logic                          a_gauss_ff;
   logic                          a_lap_ff;
   logic [wf3_pkg::PIX_W-1:0]     a_lap_val_ff;
   logic                          a_fend_ff;

   logic                          o_valid_ff;
   logic [wf3_pkg::PIX_W-1:0]     o_pixel_ff;
   logic                          o_fend_ff;

   logic                          o_ready, a_ready, a_move;
   logic [wf3_pkg::SUM_W-1:0]     sum9, cross_sum, gauss, operand_in;
   logic signed [wf3_pkg::SUM_W-1:0] lap;
   logic [wf3_pkg::PIX_W-1:0]     lap_val_in;
   logic [wf3_pkg::SUM_W+wf3_pkg::RECIP_W-1:0] prod;
   logic [wf3_pkg::PIX_W-1:0]     pixel_in;

   assign o_ready = !o_valid_ff || !rsp_stall;
   assign a_move  = a_valid_ff && o_ready;
   assign a_ready = !a_valid_ff || o_ready;
   assign pop     = head_valid && a_ready;

   always_comb begin
      sum9 = '0;
      for (int i = 0; i < 9; i++) begin
         sum9 = sum9 + wf3_pkg::SUM_W'(head_item.win[i]);
      end
      cross_sum = wf3_pkg::SUM_W'(head_item.win[1]) + wf3_pkg::SUM_W'(head_item.win[3])
                + wf3_pkg::SUM_W'(head_item.win[5]) + wf3_pkg::SUM_W'(head_item.win[7]);
      gauss = cross_sum + (wf3_pkg::SUM_W'(head_item.win[4]) << 1);
      lap   = $signed(wf3_pkg::SUM_W'(head_item.win[4]) << 2) - $signed(cross_sum);
      if (lap < 0) begin
         lap_val_in = '0;
      end else if (lap > $signed(wf3_pkg::SUM_W'(255))) begin
         lap_val_in = '1;
      end else begin
         lap_val_in = lap[wf3_pkg::PIX_W-1:0];
      end
      operand_in = (filter_mode == wf3_pkg::MODE_GAUSS) ? gauss : sum9;
   end

   assign prod = a_operand_ff
               * (a_gauss_ff ? wf3_pkg::GAUSS_RECIP : wf3_pkg::BOX_RECIP);
   assign pixel_in = a_lap_ff ? a_lap_val_ff
                   : prod[wf3_pkg::RECIP_SHIFT +: wf3_pkg::PIX_W];

   always_ff @(posedge clock) begin
      if (pop) begin
         a_operand_ff <= operand_in;
         a_gauss_ff   <= filter_mode == wf3_pkg::MODE_GAUSS;
         a_lap_ff     <= filter_mode == wf3_pkg::MODE_LAP;
         a_lap_val_ff <= lap_val_in;
         a_fend_ff    <= head_item.frame_end;
      end
      if (a_move) begin
         o_pixel_ff <= pixel_in;
         o_fend_ff  <= a_fend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= pop;
         end
         if (o_ready) begin
            o_valid_ff <= a_move;
         end
      end
   end

   assign rsp_valid     = o_valid_ff;
   assign rsp_pixel_out = o_pixel_ff;
   assign rsp_frame_end = o_fend_ff;

endmodule

// ===== tb/tb_window_filter_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_window_filter_3x3
// Self-checking testbench for the streaming 3x3 window filter.
// ----------------------------------------------------------------------------
// Pixels are fed from a queue through a valid/stall driver. Every accepted
// pixel steps a local model of the two line stores, the window registers and
// the position counters; any interior result it yields is queued and compared
// field by field with the beats leaving the block. A directed part hits the
// saturation limits, the spare mode, undersized settings and a restart inside
// a frame. Random frames of random size and mode follow, with size changes and
// restarts falling mid-frame, random idle on both sides, one long output hold
// that backs the block up, and one drain pause on the input side.
// ----------------------------------------------------------------------------
module tb_window_filter_3x3;

   localparam logic [wf3_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [wf3_pkg::MODE_W-1:0]      MODE_SPARE = 2'd3;
   localparam int unsigned MIN_SIZE     = 3;
   localparam int          DRAIN_CYCLES = 16;
   localparam int          LONG_HOLD    = 120;
   localparam int          ITEM_TARGET  = 1950;
   localparam int          QUIET_FROM   = 1700;
   localparam int          HOLD_PHASE   = 3;
   localparam int          PAUSE_PHASE  = 7;

   typedef struct {
      logic [wf3_pkg::PIX_W-1:0] pixel;
      logic                      frame_start;
   } pixel_beat_type;

   typedef struct {
      logic [wf3_pkg::PIX_W-1:0] pixel;
      logic                      frame_end;
   } filtered_beat_type;

   logic                            clock           = 1'b0;
   logic                            reset           = 1'b1;
   logic                            req_valid       = 1'b0;
   logic                            req_stall;
   logic [wf3_pkg::PIX_W-1:0]       req_pixel_in    = '0;
   logic                            req_frame_start = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall       = 1'b0;
   logic [wf3_pkg::PIX_W-1:0]       rsp_pixel_out;
   logic                            rsp_frame_end;
   logic                            csr_we          = 1'b0;
   logic [wf3_pkg::CSR_INDEX_W-1:0] csr_index       = '0;
   logic [wf3_pkg::CSR_DATA_W-1:0]  csr_wdata       = '0;

   pixel_beat_type    pixel_feed_q[$];
   filtered_beat_type filtered_q[$];
   pixel_beat_type    next_px;

   // filter model state
   logic [wf3_pkg::MODE_W-1:0]   mode_m   = wf3_pkg::MODE_BOX;
   logic [wf3_pkg::WIDTH_W-1:0]  width_m  = wf3_pkg::RESET_WIDTH;
   logic [wf3_pkg::HEIGHT_W-1:0] height_m = wf3_pkg::RESET_HEIGHT;
   logic [wf3_pkg::PIX_W-1:0]    row_prev [wf3_pkg::MAX_WIDTH];
   logic [wf3_pkg::PIX_W-1:0]    row_older [wf3_pkg::MAX_WIDTH];
   logic [wf3_pkg::PIX_W-1:0]    win_m [9];
   int unsigned                  col_m = 0;
   int unsigned                  row_m = 0;

   int fail_count  = 0;
   int items_sent  = 0;
   bit req_taken   = 1'b0;
   int src_gap     = 0;
   int dst_gap     = 0;
   int hold_left   = 0;
   int hold_req    = 0;
   int hold_seen   = 0;
   bit src_idle_on = 1'b0;
   bit dst_idle_on = 1'b0;

   window_filter_3x3 i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_pixel_in    (req_pixel_in),
      .req_frame_start (req_frame_start),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_out   (rsp_pixel_out),
      .rsp_frame_end   (rsp_frame_end),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
      return (v < MIN_SIZE) ? MIN_SIZE : (v > hi) ? hi : v;
   endfunction

   function automatic logic [wf3_pkg::PIX_W-1:0] window_value();
      int unsigned cross_sum;
      int unsigned centre;
      int unsigned total;
      int          lap;
      logic [wf3_pkg::PIX_W-1:0] res;
      cross_sum = int'(win_m[1]) + int'(win_m[3]) + int'(win_m[5]) + int'(win_m[7]);
      centre    = int'(win_m[4]);
      case (mode_m)
         wf3_pkg::MODE_GAUSS: begin
            total = (cross_sum + 2 * centre) / 6;
            res = total[wf3_pkg::PIX_W-1:0];
         end
         wf3_pkg::MODE_LAP: begin
            lap = 4 * int'(centre) - int'(cross_sum);
            if (lap < 0) begin
               res = '0;
            end else if (lap > 255) begin
               res = '1;
            end else begin
               res = lap[wf3_pkg::PIX_W-1:0];
            end
         end
         default: begin
            total = 0;
            for (int k = 0; k < 9; k++) total += int'(win_m[k]);
            total = total / 9;
            res = total[wf3_pkg::PIX_W-1:0];
         end
      endcase
      return res;
   endfunction

   task automatic filter_pixel(input logic [wf3_pkg::PIX_W-1:0] pix, input logic fstart);
      int unsigned               w_eff;
      int unsigned               h_eff;
      int unsigned               c;
      int unsigned               r;
      logic [wf3_pkg::PIX_W-1:0] top;
      logic [wf3_pkg::PIX_W-1:0] mid;
      bit                        last_col;
      bit                        last_row;
      filtered_beat_type         beat;
      w_eff = eff_size(width_m, wf3_pkg::MAX_WIDTH);
      h_eff = eff_size(height_m, wf3_pkg::MAX_HEIGHT);
      if (fstart) begin
         col_m = 0;
         row_m = 0;
      end
      c = (col_m >= wf3_pkg::MAX_WIDTH) ? wf3_pkg::MAX_WIDTH - 1 : col_m;
      r = row_m;
      top = row_older[c];
      mid = row_prev[c];
      row_older[c] = mid;
      row_prev[c] = pix;
      for (int k = 0; k < 3; k++) begin
         win_m[k*3]   = win_m[k*3+1];
         win_m[k*3+1] = win_m[k*3+2];
      end
      win_m[2] = top;
      win_m[5] = mid;
      win_m[8] = pix;
      last_col = (c + 1 >= w_eff);
      last_row = (r + 1 >= h_eff);
      if (r >= 2 && c >= 2) begin
         beat.pixel = window_value();
         beat.frame_end = last_col && last_row;
         filtered_q.push_back(beat);
      end
      if (last_col) begin
         col_m = 0;
         row_m = last_row ? 0 : r + 1;
      end else begin
         col_m = c + 1;
         row_m = r;
      end
   endtask

   task automatic report_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_beat(input logic [wf3_pkg::PIX_W-1:0] pix, input logic fend);
      filtered_beat_type want;
      if (filtered_q.size() == 0) begin
         report_mismatch($sformatf("unexpected beat pixel_out %0d frame_end %0b", pix, fend));
      end else begin
         want = filtered_q.pop_front();
         if (pix !== want.pixel)
            report_mismatch($sformatf("pixel_out %0d, want %0d", pix, want.pixel));
         if (fend !== want.frame_end)
            report_mismatch($sformatf("frame_end %0b, want %0b", fend, want.frame_end));
      end
   endtask

   // sample on the rising edge
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken)
         filter_pixel(req_pixel_in, req_frame_start);
      if (!reset && rsp_valid && !rsp_stall)
         check_beat(rsp_pixel_out, rsp_frame_end);
   end

   // input driver
   always @(negedge clock) begin
      if (!req_valid || req_taken) begin
         if (src_gap > 0) begin
            src_gap--;
            req_valid <= 1'b0;
         end else if (pixel_feed_q.size() > 0) begin
            next_px = pixel_feed_q.pop_front();
            req_valid <= 1'b1;
            req_pixel_in <= next_px.pixel;
            req_frame_start <= next_px.frame_start;
            if (src_idle_on && $urandom_range(0, 5) == 0)
               src_gap = $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // output receiver
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (dst_gap > 0) begin
         dst_gap--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (dst_idle_on && $urandom_range(0, 5) == 0)
            dst_gap = $urandom_range(1, 3);
      end
   end

   task automatic wait_drain();
      while (pixel_feed_q.size() != 0 || req_valid || filtered_q.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input logic [wf3_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [wf3_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         wf3_pkg::CSR_FILTER_MODE:  mode_m = data[wf3_pkg::MODE_W-1:0];
         wf3_pkg::CSR_IMAGE_WIDTH:  width_m = data[wf3_pkg::WIDTH_W-1:0];
         wf3_pkg::CSR_IMAGE_HEIGHT: height_m = data[wf3_pkg::HEIGHT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // upper bits beyond each register are random
   task automatic configure(input logic [wf3_pkg::MODE_W-1:0] mode,
                            input int unsigned w_cfg, input int unsigned h_cfg);
      logic [wf3_pkg::CSR_DATA_W-1:0] data;
      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      data = wf3_pkg::CSR_DATA_W'($urandom);
      data[wf3_pkg::MODE_W-1:0] = mode;
      write_csr(wf3_pkg::CSR_FILTER_MODE, data);
      data = wf3_pkg::CSR_DATA_W'($urandom);
      data[wf3_pkg::WIDTH_W-1:0] = wf3_pkg::WIDTH_W'(w_cfg);
      write_csr(wf3_pkg::CSR_IMAGE_WIDTH, data);
      write_csr(wf3_pkg::CSR_IMAGE_HEIGHT, wf3_pkg::CSR_DATA_W'(h_cfg));
      if ($urandom_range(0, 3) == 0)
         write_csr(CSR_UNUSED, wf3_pkg::CSR_DATA_W'($urandom));
   endtask

   task automatic push_pixel(input logic [wf3_pkg::PIX_W-1:0] pix, input logic fstart);
      pixel_beat_type beat;
      beat.pixel = pix;
      beat.frame_start = fstart;
      pixel_feed_q.push_back(beat);
      items_sent++;
   endtask

   function automatic logic [wf3_pkg::PIX_W-1:0] rand_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         default: return wf3_pkg::PIX_W'($urandom);
      endcase
   endfunction

   initial begin
      int unsigned w_cfg;
      int unsigned h_cfg;
      int unsigned w_eff;
      int unsigned h_eff;
      int unsigned n_items;
      int unsigned pick;
      logic [wf3_pkg::MODE_W-1:0] mode;
      bit quiet;
      bit start;
      int phase;

      foreach (row_prev[i]) begin
         row_prev[i] = '0;
         row_older[i] = '0;
      end
      foreach (win_m[i]) win_m[i] = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      src_idle_on = 1'b1;
      dst_idle_on = 1'b1;

      // flat white frame keeps the cross gaussian at full scale
      configure(wf3_pkg::MODE_GAUSS, 3, 3);
      write_csr(CSR_UNUSED, '1);
      for (int i = 0; i < 9; i++) push_pixel('1, i == 0);

      // laplacian saturating high on a bright dot, then low beside it
      configure(wf3_pkg::MODE_LAP, 4, 3);
      for (int i = 0; i < 12; i++) push_pixel((i == 5) ? '1 : '0, i == 0);

      // spare mode acts as box mean, undersized settings clamp, restart mid-frame
      configure(MODE_SPARE, 0, 1);
      push_pixel(8'h80, 1'b1);
      push_pixel(8'h7F, 1'b0);
      for (int i = 0; i < 9; i++) push_pixel(wf3_pkg::PIX_W'(i * 29 + 7), i == 0);

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         quiet = (items_sent >= QUIET_FROM);
         mode = wf3_pkg::MODE_W'($urandom_range(0, 3));
         pick = $urandom_range(0, 15);
         if (pick == 0) w_cfg = $urandom_range(0, 2);
         else if (pick == 1) w_cfg = $urandom_range(wf3_pkg::MAX_WIDTH + 1, 2047);
         else if (pick == 2) w_cfg = wf3_pkg::MAX_WIDTH;
         else w_cfg = $urandom_range(3, 12);
         pick = $urandom_range(0, 15);
         if (pick == 0) h_cfg = $urandom_range(0, 2);
         else if (pick == 1) h_cfg = $urandom_range(wf3_pkg::MAX_HEIGHT + 1, 8191);
         else h_cfg = $urandom_range(3, 8);
         if (phase == HOLD_PHASE) begin
            w_cfg = 8;
            h_cfg = 8;
         end else if (phase == PAUSE_PHASE) begin
            w_cfg = 6;
            h_cfg = 6;
         end
         configure(mode, w_cfg, h_cfg);
         src_idle_on = !quiet && $urandom_range(0, 3) != 0;
         dst_idle_on = !quiet && $urandom_range(0, 3) != 0;
         w_eff = eff_size(w_cfg, wf3_pkg::MAX_WIDTH);
         h_eff = eff_size(h_cfg, wf3_pkg::MAX_HEIGHT);
         if (w_eff * h_eff > 200)
            n_items = $urandom_range(20, 80);
         else
            n_items = w_eff * h_eff * $urandom_range(1, 3) + $urandom_range(0, 2 * w_eff);
         if (n_items > ITEM_TARGET - items_sent)
            n_items = ITEM_TARGET - items_sent;
         start = (phase == HOLD_PHASE || phase == PAUSE_PHASE || $urandom_range(0, 3) != 0);
         if (phase == HOLD_PHASE) hold_req++;
         for (int k = 0; k < n_items; k++) begin
            if (phase == PAUSE_PHASE && k == n_items / 2) wait_drain();
            push_pixel(rand_pixel(), (k == 0 && start) || $urandom_range(0, 63) == 0);
         end
         phase++;
      end

      wait_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("tb_window_filter_3x3 OK");
      else
         $display("tb_window_filter_3x3 NOT OK");
      $finish;
   end

   initial begin
      #400000;
      $display("tb_window_filter_3x3 NOT OK");
      $finish;
   end

endmodule
